/* rtl/uart_rf_pkg.sv */
// Package for the UART register file: transaction payload types,
// function and register offset codes, and fixed register values.
// No dependencies.
package uart_rf_pkg;

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] offset;
        logic [7:0] data;
    } t_req;

    typedef struct packed {
        logic [7:0] rdata;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq;
        logic       rx_dropped;
    } t_rsp;

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_PUSH  = 2'd2;

    localparam logic [2:0] OFF_RBR_THR = 3'd0;
    localparam logic [2:0] OFF_IER     = 3'd1;
    localparam logic [2:0] OFF_IIR     = 3'd2;
    localparam logic [2:0] OFF_LCR     = 3'd3;
    localparam logic [2:0] OFF_MCR     = 3'd4;
    localparam logic [2:0] OFF_LSR     = 3'd5;
    localparam logic [2:0] OFF_MSR     = 3'd6;
    localparam logic [2:0] OFF_SCR     = 3'd7;

    localparam int unsigned LCR_DLAB_BIT = 7;
    localparam int unsigned IER_RX_BIT   = 0;

    localparam logic [7:0] IIR_RX_PENDING = 8'h04;
    localparam logic [7:0] IIR_NONE       = 8'h01;
    localparam logic [7:0] LSR_BASE       = 8'h60;
    localparam logic [7:0] MSR_VALUE      = 8'hB0;

endpackage

/* rtl/uart_rf_if.sv */
// Valid/ready channel interfaces for the UART register file.
// Depends on uart_rf_pkg for the payload types.
interface uart_rf_req_if import uart_rf_pkg::*;;
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface uart_rf_rsp_if import uart_rf_pkg::*;;
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/uart_register_file_with_rx_fifo.sv */
// Top level of the 16550-style UART register file with its receive FIFO.
// Depends on uart_rf_pkg, the channel interfaces and uart_rf_ram.
//
// Usage.
// The request channel carries one transaction per access: a register read,
// a register write (offsets 0 to 7) or a received byte to be pushed into
// the receive FIFO. Every request transaction yields exactly one response
// transaction with the read data, the transmit byte of a THR write, the
// interrupt level after the access and a flag for a dropped receive byte.
// The FIFO bytes live in a synchronous RAM with a registered read; the
// pointers, the fill count and the control registers live in flip-flops
// and are updated at the edge that accepts the request, so the next
// request sees them at once; one transaction per cycle is sustained
// while the receiver takes the responses. A response passes the stage
// that waits for the RAM read of a FIFO pop, then the output queue.
// The output side holds a two-entry queue, so a new request is still taken
// while one finished response waits; only when two results are pending and
// the receiver stalls does the request ready drop.
// Reset clears the control registers, the pointers and the fill count, so
// the FIFO is empty at once; the RAM is not cleared, as only bytes that
// were pushed are ever read.
module uart_register_file_with_rx_fifo
    import uart_rf_pkg::*;
#(
    parameter int RX_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    uart_rf_req_if.sink    i_req,
    uart_rf_rsp_if.source  o_rsp
);

    localparam int PW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int CW = $clog2(RX_DEPTH + 1);

    // Architectural registers.
    logic [7:0]    r_ier, n_ier;
    logic [7:0]    r_lcr, n_lcr;
    logic [7:0]    r_mcr, n_mcr;
    logic [7:0]    r_scr, n_scr;
    logic [7:0]    r_dll, n_dll;
    logic [7:0]    r_dlm, n_dlm;
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    // Stage after acceptance: waits for the RAM read of a pop.
    logic          r_s1_valid;
    logic          r_s1_pop;
    t_rsp          r_s1_rsp;

    // Two-entry output queue.
    logic [1:0]    r_qcnt, n_qcnt;
    t_rsp          r_q0, n_q0;
    t_rsp          r_q1, n_q1;

    t_req          req;
    t_rsp          rsp;
    t_rsp          s1_resolved;
    logic          accept;
    logic          out_take;
    logic          dlab;
    logic          not_empty;
    logic          full;
    logic          pop;
    logic          push;
    logic [1:0]    occupancy;
    logic [7:0]    ram_rdata;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == PW'(RX_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign req      = i_req.payload;
    assign accept   = i_req.valid && i_req.ready;
    assign out_take = o_rsp.valid && o_rsp.ready;

    // Results still held after this edge must fit in the output queue.
    assign occupancy   = r_qcnt + {1'b0, r_s1_valid} - {1'b0, out_take};
    assign i_req.ready = (occupancy < 2'd2);

    assign dlab      = r_lcr[LCR_DLAB_BIT];
    assign not_empty = (r_count != '0);
    assign full      = (r_count == CW'(RX_DEPTH));

    // Decode of the accepted access against the current register state.
    always_comb begin
        n_ier   = r_ier;
        n_lcr   = r_lcr;
        n_mcr   = r_mcr;
        n_scr   = r_scr;
        n_dll   = r_dll;
        n_dlm   = r_dlm;
        rsp     = '0;
        pop     = 1'b0;
        push    = 1'b0;
        if (accept) begin
            case (req.func)
                FUNC_READ: begin
                    case (req.offset)
                        OFF_RBR_THR: begin
                            if (dlab) begin
                                rsp.rdata = r_dll;
                            end else if (not_empty) begin
                                pop = 1'b1;
                            end
                        end
                        OFF_IER: rsp.rdata = dlab ? r_dlm : r_ier;
                        OFF_IIR: begin
                            rsp.rdata = (r_ier[IER_RX_BIT] && not_empty) ?
                                        IIR_RX_PENDING : IIR_NONE;
                        end
                        OFF_LCR: rsp.rdata = r_lcr;
                        OFF_MCR: rsp.rdata = r_mcr;
                        OFF_LSR: rsp.rdata = LSR_BASE | {7'd0, not_empty};
                        OFF_MSR: rsp.rdata = MSR_VALUE;
                        default: rsp.rdata = r_scr;
                    endcase
                end
                FUNC_WRITE: begin
                    case (req.offset)
                        OFF_RBR_THR: begin
                            if (dlab) begin
                                n_dll = req.data;
                            end else begin
                                rsp.tx_valid = 1'b1;
                                rsp.tx_byte  = req.data;
                            end
                        end
                        OFF_IER: begin
                            if (dlab) begin
                                n_dlm = req.data;
                            end else begin
                                n_ier = req.data;
                            end
                        end
                        OFF_LCR: n_lcr = req.data;
                        OFF_MCR: n_mcr = req.data;
                        OFF_SCR: n_scr = req.data;
                        default: ;
                    endcase
                end
                FUNC_PUSH: begin
                    if (full) begin
                        rsp.rx_dropped = 1'b1;
                    end else begin
                        push = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        n_head  = pop  ? ring_next(r_head) : r_head;
        n_tail  = push ? ring_next(r_tail) : r_tail;
        if (push) begin
            n_count = r_count + CW'(1);
        end else if (pop) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
        // The interrupt level reflects the state after this access.
        rsp.irq = n_ier[IER_RX_BIT] && (n_count != '0);
    end

    // A push writes at its accepting edge, so a pop in the next cycle
    // already reads the new byte; a push and a pop never share an access.
    uart_rf_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_tail),
        .i_wdata (req.data),
        .i_re    (pop),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        s1_resolved = r_s1_rsp;
        if (r_s1_pop) begin
            s1_resolved.rdata = ram_rdata;
        end
    end

    // Output queue: shift out on a take, then append the stage result.
    always_comb begin
        n_q0   = out_take ? r_q1 : r_q0;
        n_q1   = r_q1;
        n_qcnt = r_qcnt - {1'b0, out_take};
        if (r_s1_valid) begin
            if (n_qcnt == 2'd0) begin
                n_q0 = s1_resolved;
            end else begin
                n_q1 = s1_resolved;
            end
            n_qcnt = n_qcnt + 2'd1;
        end
    end

    assign o_rsp.valid   = (r_qcnt != 2'd0);
    assign o_rsp.payload = r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ier      <= '0;
            r_lcr      <= '0;
            r_mcr      <= '0;
            r_scr      <= '0;
            r_dll      <= '0;
            r_dlm      <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_s1_valid <= 1'b0;
            r_qcnt     <= 2'd0;
        end else begin
            r_ier      <= n_ier;
            r_lcr      <= n_lcr;
            r_mcr      <= n_mcr;
            r_scr      <= n_scr;
            r_dll      <= n_dll;
            r_dlm      <= n_dlm;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_s1_valid <= accept;
            r_qcnt     <= n_qcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pop <= pop;
        r_s1_rsp <= rsp;
        r_q0     <= n_q0;
        r_q1     <= n_q1;
    end

endmodule

/* rtl/uart_rf_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module uart_rf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/uart_rf_checker.sv */
// Port-level checker for the UART register file and its bind statement.
// Depends on uart_rf_pkg and the top level uart_register_file_with_rx_fifo.
module uart_rf_checker
    import uart_rf_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp_payload
);

    logic req_acc;

    assign req_acc = i_req_valid && i_req_ready;

    // A stalled response stays offered.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("response withdrawn while stalled");

    // A stalled response keeps its payload.
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> $stable(i_rsp_payload))
        else $error("response payload changed while stalled");

    // Without accepted requests, an idle response channel cannot start offering a response.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!req_acc ##1 (!req_acc && !i_rsp_valid)) |=> !i_rsp_valid)
        else $error("response without a request transaction");

    // Reset empties the output side.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

endmodule

bind uart_register_file_with_rx_fifo uart_rf_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_payload (o_rsp.payload)
);

/* sim/tb_top.sv */
// Self-checking testbench for the UART register file with its receive FIFO.
// Needs uart_rf_pkg, the channel interfaces and the RTL of the block.
// Directed rows, then random bursts; responses are held to typed or predicted values.
module tb_top;
    import uart_rf_pkg::*;

    // The package names no code for the unused function value.
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int RX_DEPTH_TB = 16;
    localparam int N_DIRECTED = 25;
    localparam int N_BURSTS = 50;
    localparam int BURST_LEN = 25;
    localparam int STALL_LIMIT = 200;
    localparam int REPORT_LIMIT = 10;

    typedef enum int {
        BURST_MIXED,
        BURST_FILL,
        BURST_DRAIN,
        BURST_CONFIG
    } t_burst;

    // One row of the directed table. Where has_rsp is set, the response is
    // typed in; otherwise the predictor supplies it.
    typedef struct {
        t_req req;
        bit   has_rsp;
        t_rsp rsp;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    uart_rf_req_if req_ch ();
    uart_rf_rsp_if rsp_ch ();

    uart_register_file_with_rx_fifo #(
        .RX_DEPTH(RX_DEPTH_TB)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // Shadow copy of the register file and the receive FIFO.
    logic [7:0] sh_ier;
    logic [7:0] sh_lcr;
    logic [7:0] sh_mcr;
    logic [7:0] sh_scr;
    logic [7:0] sh_dll;
    logic [7:0] sh_dlm;
    logic [7:0] sh_rx_bytes[$];

    t_rsp pending_rsp[$];
    int   mismatch_count;
    bit   idle_on;
    t_row dir_rows[N_DIRECTED];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit shadow_irq();
        return sh_ier[IER_RX_BIT] && (sh_rx_bytes.size() != 0);
    endfunction

    // Applies one request transaction to the shadow state and returns the
    // response that the block must give for it.
    function automatic t_rsp uart_step(input t_req r);
        t_rsp rsp;
        bit   dlab;
        rsp = '0;
        dlab = sh_lcr[LCR_DLAB_BIT];
        case (r.func)
            FUNC_READ: begin
                case (r.offset)
                    OFF_RBR_THR: begin
                        if (dlab) begin
                            rsp.rdata = sh_dll;
                        end else if (sh_rx_bytes.size() != 0) begin
                            rsp.rdata = sh_rx_bytes[0];
                            sh_rx_bytes.delete(0);
                        end
                    end
                    OFF_IER: rsp.rdata = dlab ? sh_dlm : sh_ier;
                    OFF_IIR: rsp.rdata = shadow_irq() ? IIR_RX_PENDING : IIR_NONE;
                    OFF_LCR: rsp.rdata = sh_lcr;
                    OFF_MCR: rsp.rdata = sh_mcr;
                    OFF_LSR: rsp.rdata = LSR_BASE | {7'd0, sh_rx_bytes.size() != 0};
                    OFF_MSR: rsp.rdata = MSR_VALUE;
                    default: rsp.rdata = sh_scr;
                endcase
            end
            FUNC_WRITE: begin
                case (r.offset)
                    OFF_RBR_THR: begin
                        if (dlab) begin
                            sh_dll = r.data;
                        end else begin
                            rsp.tx_valid = 1'b1;
                            rsp.tx_byte = r.data;
                        end
                    end
                    OFF_IER: begin
                        if (dlab) sh_dlm = r.data;
                        else sh_ier = r.data;
                    end
                    OFF_LCR: sh_lcr = r.data;
                    OFF_MCR: sh_mcr = r.data;
                    OFF_SCR: sh_scr = r.data;
                    default: ;
                endcase
            end
            FUNC_PUSH: begin
                if (sh_rx_bytes.size() >= RX_DEPTH_TB) rsp.rx_dropped = 1'b1;
                else sh_rx_bytes = {sh_rx_bytes, r.data};
            end
            default: ;
        endcase
        rsp.irq = shadow_irq();
        return rsp;
    endfunction

    function automatic t_row mk_row(input logic [1:0] func, input logic [2:0] offset,
                                    input logic [7:0] data, input bit has_rsp,
                                    input logic [7:0] rdata, input logic tx_valid,
                                    input logic [7:0] tx_byte, input logic irq,
                                    input logic rx_dropped);
        t_row row;
        row.req = t_req'{func, offset, data};
        row.has_rsp = has_rsp;
        row.rsp = t_rsp'{rdata, tx_valid, tx_byte, irq, rx_dropped};
        return row;
    endfunction

    function automatic int draw_wait();
        return idle_on ? $urandom_range(0, 3) : 0;
    endfunction

    // Draws a random request. Fill bursts push the FIFO towards full, drain
    // bursts pop it, configuration bursts toggle the divisor latch access.
    function automatic t_req draw_req(input t_burst mode);
        t_req r;
        int   pick;
        pick = $urandom_range(0, 99);
        r.offset = 3'($urandom_range(0, 7));
        r.data = 8'($urandom);
        case (mode)
            BURST_FILL: begin
                r.func = (pick < 70) ? FUNC_PUSH : (pick < 90) ? FUNC_READ : FUNC_WRITE;
            end
            BURST_DRAIN: begin
                if (pick < 60) begin
                    r.func = FUNC_READ;
                    r.offset = OFF_RBR_THR;
                end else if (pick < 75) begin
                    r.func = FUNC_READ;
                end else if (pick < 90) begin
                    r.func = FUNC_PUSH;
                end else begin
                    r.func = FUNC_WRITE;
                end
            end
            BURST_CONFIG: begin
                r.func = (pick < 50) ? FUNC_WRITE : FUNC_READ;
                if (pick < 20) r.offset = OFF_LCR;
            end
            default: begin
                r.func = (pick < 5) ? FUNC_NONE : 2'($urandom_range(0, 2));
            end
        endcase
        // Outside configuration bursts, keep the latch access mostly off so
        // that reads of offset 0 reach the FIFO.
        if (r.func == FUNC_WRITE && r.offset == OFF_LCR && mode != BURST_CONFIG
                && $urandom_range(0, 3) != 0) begin
            r.data[LCR_DLAB_BIT] = 1'b0;
        end
        return r;
    endfunction

    // Offers one request transaction and, once it is accepted, records the
    // response it must produce. valid stays high across back-to-back items.
    task automatic drive_req(input t_req r, input bit has_rsp, input t_rsp typed_rsp);
        int   gap;
        t_rsp predicted;
        gap = draw_wait();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = uart_step(r);
        pending_rsp = {pending_rsp, (has_rsp ? typed_rsp : predicted)};
    endtask

    // Stops offering requests until every outstanding response has arrived.
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    // Response side: stalls at random, then compares each accepted response
    // transaction with the oldest expectation.
    initial begin : rsp_checker
        int   stall;
        t_rsp want;
        t_rsp got;
        bit   bad;
        rsp_ch.ready <= 1'b0;
        mismatch_count = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            got = rsp_ch.payload;
            if (pending_rsp.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("unexpected: rdata=%h txv=%b txb=%h irq=%b drop=%b",
                             got.rdata, got.tx_valid, got.tx_byte, got.irq, got.rx_dropped);
                end
            end else begin
                want = pending_rsp[0];
                pending_rsp.delete(0);
                bad = (got.rdata !== want.rdata) || (got.tx_valid !== want.tx_valid)
                    || (got.tx_byte !== want.tx_byte) || (got.irq !== want.irq)
                    || (got.rx_dropped !== want.rx_dropped);
                if (bad) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("mismatch expected: rdata=%h txv=%b txb=%h irq=%b drop=%b",
                                 want.rdata, want.tx_valid, want.tx_byte, want.irq,
                                 want.rx_dropped);
                        $display("         actual:   rdata=%h txv=%b txb=%h irq=%b drop=%b",
                                 got.rdata, got.tx_valid, got.tx_byte, got.irq,
                                 got.rx_dropped);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if no transaction moves on either channel for
    // too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
            else quiet++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin : stimulus
        t_burst mode;
        req_ch.valid <= 1'b0;
        req_ch.payload <= '0;
        i_rst_n <= 1'b0;
        sh_ier = '0;
        sh_lcr = '0;
        sh_mcr = '0;
        sh_scr = '0;
        sh_dll = '0;
        sh_dlm = '0;
        sh_rx_bytes.delete();
        idle_on = 1'b1;

        dir_rows = '{
            // Computed registers straight after reset, and a read of the empty FIFO.
            mk_row(FUNC_READ,  OFF_IIR,     8'h00, 1, IIR_NONE, 0, 8'h00, 0, 0),
            mk_row(FUNC_READ,  OFF_LSR,     8'h00, 1, LSR_BASE, 0, 8'h00, 0, 0),
            mk_row(FUNC_READ,  OFF_MSR,     8'h00, 1, MSR_VALUE, 0, 8'h00, 0, 0),
            mk_row(FUNC_READ,  OFF_RBR_THR, 8'h00, 1, 8'h00, 0, 8'h00, 0, 0),
            mk_row(FUNC_READ,  OFF_IER,     8'h00, 1, 8'h00, 0, 8'h00, 0, 0),
            // Transmit bytes at both extremes, then the receive interrupt enabled.
            mk_row(FUNC_WRITE, OFF_RBR_THR, 8'hFF, 1, 8'h00, 1, 8'hFF, 0, 0),
            mk_row(FUNC_WRITE, OFF_RBR_THR, 8'h00, 1, 8'h00, 1, 8'h00, 0, 0),
            mk_row(FUNC_WRITE, OFF_IER,     8'hFF, 1, 8'h00, 0, 8'h00, 0, 0),
            // Received bytes raise the interrupt while the receive enable is set; reading them back clears it.
            mk_row(FUNC_PUSH,  OFF_RBR_THR, 8'hFF, 1, 8'h00, 0, 8'h00, 1, 0),
            mk_row(FUNC_PUSH,  OFF_SCR,     8'h00, 0, 8'h00, 0, 8'h00, 0, 0),
            mk_row(FUNC_READ,  OFF_IIR,     8'h00, 1, IIR_RX_PENDING, 0, 8'h00, 1, 0),
            mk_row(FUNC_READ,  OFF_LSR,     8'h00, 1, LSR_BASE | 8'h01, 0, 8'h00, 1, 0),
            mk_row(FUNC_READ,  OFF_RBR_THR, 8'h00, 1, 8'hFF, 0, 8'h00, 1, 0),
            mk_row(FUNC_READ,  OFF_RBR_THR, 8'h00, 1, 8'h00, 0, 8'h00, 0, 0),
            mk_row(FUNC_READ,  OFF_RBR_THR, 8'h00, 1, 8'h00, 0, 8'h00, 0, 0),
            // Divisor latch access, and the scratch register.
            mk_row(FUNC_WRITE, OFF_LCR,     8'h80, 1, 8'h00, 0, 8'h00, 0, 0),
            mk_row(FUNC_WRITE, OFF_RBR_THR, 8'hFF, 0, 8'h00, 0, 8'h00, 0, 0),
            mk_row(FUNC_WRITE, OFF_IER,     8'h00, 0, 8'h00, 0, 8'h00, 0, 0),
            mk_row(FUNC_READ,  OFF_RBR_THR, 8'h00, 1, 8'hFF, 0, 8'h00, 0, 0),
            mk_row(FUNC_READ,  OFF_IER,     8'h00, 0, 8'h00, 0, 8'h00, 0, 0),
            mk_row(FUNC_WRITE, OFF_SCR,     8'hFF, 0, 8'h00, 0, 8'h00, 0, 0),
            mk_row(FUNC_READ,  OFF_SCR,     8'h00, 1, 8'hFF, 0, 8'h00, 0, 0),
            // A write to a read-only offset and the unused function code do nothing; then DLAB is cleared.
            mk_row(FUNC_WRITE, OFF_IIR,     8'h5A, 0, 8'h00, 0, 8'h00, 0, 0),
            mk_row(FUNC_NONE,  OFF_SCR,     8'hFF, 0, 8'h00, 0, 8'h00, 0, 0),
            mk_row(FUNC_WRITE, OFF_LCR,     8'h00, 0, 8'h00, 0, 8'h00, 0, 0)
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            drive_req(dir_rows[k].req, dir_rows[k].has_rsp, dir_rows[k].rsp);
        end
        drain_responses();

        // Random bursts; each one picks its flavour and whether both sides idle.
        for (int b = 0; b < N_BURSTS; b++) begin
            mode = t_burst'($urandom_range(0, 3));
            idle_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < BURST_LEN; k++) begin
                drive_req(draw_req(mode), 1'b0, '0);
            end
            if (b % 10 == 9) drain_responses();
        end

        drain_responses();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_rsp.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
